[hdl/mwq_pkg.sv]
// Shared types and constants for the mutex unit with wait queues.
// Used by mwq_front, mwq_back and the top level; no dependencies.
package mwq_pkg;

    localparam int MUTEX_ID_W  = 4;
    localparam int PID_IN_W    = 8;
    localparam int STATUS_W    = 3;
    localparam int WOKEN_W     = 8;
    localparam int IDX_MAX_W   = 8;
    localparam int PID_MAX_W   = 16;
    localparam int OPQ_DEPTH   = 2;
    localparam int OPQ_PTR_W   = 1;
    localparam int OPQ_CNT_W   = 2;

    typedef enum logic {
        OP_LOCK   = 1'b0,
        OP_UNLOCK = 1'b1
    } op_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED = 3'd0,
        ST_QUEUED  = 3'd1,
        ST_FULL    = 3'd2,
        ST_HANDED  = 3'd3,
        ST_FREE    = 3'd4
    } status_t;

    typedef struct packed {
        op_kind_t              kind;
        logic [IDX_MAX_W-1:0]  mutex;
        logic [PID_MAX_W-1:0]  pid;
    } op_t;

endpackage

[hdl/mwq_front.sv]
// Front end: accepts request beats, reduces the mutex id, masks the pid,
// and buffers decoded ops in a two-entry queue. Depends on mwq_pkg.
module mwq_front #(
    parameter int NUM_MUTEXES = 16,
    parameter int PID_BITS    = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [3:0] mutex_id, [11:4] pid, [15:12] zero
    input  logic [15:0]                        s_tdata,
    // [0] kind
    input  logic                               s_tuser,
    output logic                               op_valid,
    input  logic                               op_ready,
    output mwq_pkg::op_t                       op
);

    localparam int MW      = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
    localparam int ID_VALS = 2 ** mwq_pkg::MUTEX_ID_W;

    logic [MW-1:0] mod_lut [ID_VALS];

    for (genvar v = 0; v < ID_VALS; v++) begin : g_mod
        assign mod_lut[v] = MW'(v % NUM_MUTEXES);
    end

    logic [mwq_pkg::MUTEX_ID_W-1:0] in_id;
    logic [mwq_pkg::PID_IN_W-1:0]   in_pid;
    logic [PID_BITS-1:0]            pid_k;
    mwq_pkg::op_t                   op_in;

    assign in_id  = s_tdata[mwq_pkg::MUTEX_ID_W-1:0];
    assign in_pid = s_tdata[mwq_pkg::MUTEX_ID_W +: mwq_pkg::PID_IN_W];
    assign pid_k  = PID_BITS'(in_pid);

    always_comb begin
        op_in.kind  = mwq_pkg::op_kind_t'(s_tuser);
        op_in.mutex = mwq_pkg::IDX_MAX_W'(mod_lut[in_id]);
        op_in.pid   = mwq_pkg::PID_MAX_W'(pid_k);
    end

    mwq_pkg::op_t                  q_reg [mwq_pkg::OPQ_DEPTH];
    logic [mwq_pkg::OPQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mwq_pkg::OPQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mwq_pkg::OPQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          push, pop;

    assign s_tready = (cnt_reg != mwq_pkg::OPQ_CNT_W'(mwq_pkg::OPQ_DEPTH));
    assign op_valid = (cnt_reg != '0);
    assign op       = q_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = op_valid && op_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

[hdl/mwq_back.sv]
// Back end: read-modify-write of the per-mutex control entry, wait queue
// storage, and the result register. Depends on mwq_pkg.
module mwq_back #(
    parameter int NUM_MUTEXES = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int PID_BITS    = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          op_valid,
    output logic                          op_ready,
    input  mwq_pkg::op_t                  op,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] woken_pid
    output logic [mwq_pkg::WOKEN_W-1:0]   m_tdata,
    // [2:0] status
    output logic [mwq_pkg::STATUS_W-1:0]  m_tuser
);

    localparam int MW     = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
    localparam int QW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int MDEPTH = 2 ** MW;
    localparam int WDEPTH = 2 ** (MW + QW);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_WAKE = 3'b100
    } state_t;

    typedef struct packed {
        logic          locked;
        logic [CW-1:0] cnt;
        logic [QW-1:0] head;
        logic [QW-1:0] tail;
    } ctl_t;

    ctl_t                ctl_mem  [MDEPTH];
    logic [PID_BITS-1:0] wait_mem [WDEPTH];
    logic                vld_reg  [MDEPTH];

    state_t                state_reg, state_next;
    mwq_pkg::op_t          op_reg;
    ctl_t                  ctl_rd_reg;
    logic                  vld_rd_reg;
    logic [PID_BITS-1:0]   ws_rd_reg;
    logic                  m_tvalid_reg;
    mwq_pkg::status_t      m_status_reg;
    logic [mwq_pkg::WOKEN_W-1:0] m_woken_reg;

    logic                  out_free, do_eval, do_wake, take;
    logic [MW-1:0]         op_m, cur_m;
    ctl_t                  eff, ctl_new;
    mwq_pkg::status_t      status_new;
    logic                  handover, enq;
    logic [PID_BITS-1:0]   cur_pid;

    function automatic logic [QW-1:0] next_slot(input logic [QW-1:0] p);
        return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + QW'(1);
    endfunction

    assign out_free = !m_tvalid_reg || m_tready;
    assign op_ready = (state_reg == S_IDLE);
    assign take     = op_valid && op_ready;
    assign do_eval  = (state_reg == S_EVAL) && out_free;
    assign do_wake  = (state_reg == S_WAKE) && out_free;
    assign op_m     = op.mutex[MW-1:0];
    assign cur_m    = op_reg.mutex[MW-1:0];
    assign cur_pid  = op_reg.pid[PID_BITS-1:0];
    assign eff      = vld_rd_reg ? ctl_rd_reg : '0;

    always_comb begin
        ctl_new    = eff;
        status_new = mwq_pkg::ST_FREE;
        handover   = 1'b0;
        enq        = 1'b0;
        unique case (op_reg.kind)
            mwq_pkg::OP_LOCK: begin
                if (!eff.locked) begin
                    ctl_new.locked = 1'b1;
                    status_new     = mwq_pkg::ST_GRANTED;
                end else if (eff.cnt != CW'(QUEUE_DEPTH)) begin
                    enq          = 1'b1;
                    ctl_new.tail = next_slot(eff.tail);
                    ctl_new.cnt  = eff.cnt + CW'(1);
                    status_new   = mwq_pkg::ST_QUEUED;
                end else begin
                    status_new = mwq_pkg::ST_FULL;
                end
            end
            mwq_pkg::OP_UNLOCK: begin
                if (eff.cnt != '0) begin
                    handover     = 1'b1;
                    ctl_new.head = next_slot(eff.head);
                    ctl_new.cnt  = eff.cnt - CW'(1);
                    status_new   = mwq_pkg::ST_HANDED;
                end else begin
                    ctl_new.locked = 1'b0;
                    status_new     = mwq_pkg::ST_FREE;
                end
            end
            default: begin
                status_new = mwq_pkg::ST_FREE;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (take) state_next = S_EVAL;
            S_EVAL: if (do_eval) state_next = handover ? S_WAKE : S_IDLE;
            S_WAKE: if (do_wake) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < MDEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            if (do_eval) begin
                vld_reg[cur_m] <= 1'b1;
            end
            if ((do_eval && !handover) || do_wake) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            op_reg     <= op;
            ctl_rd_reg <= ctl_mem[op_m];
            vld_rd_reg <= vld_reg[op_m];
        end
        if (do_eval) begin
            ctl_mem[cur_m] <= ctl_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_eval && enq) begin
            wait_mem[{cur_m, eff.tail}] <= cur_pid;
        end
        if (do_eval) begin
            ws_rd_reg <= wait_mem[{cur_m, eff.head}];
        end
    end

    always_ff @(posedge aclk) begin
        if (do_eval && !handover) begin
            m_status_reg <= status_new;
            m_woken_reg  <= '0;
        end else if (do_wake) begin
            m_status_reg <= mwq_pkg::ST_HANDED;
            m_woken_reg  <= mwq_pkg::WOKEN_W'(ws_rd_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_woken_reg;
    assign m_tuser  = m_status_reg;

    a_woken_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_status_reg != mwq_pkg::ST_HANDED) |-> (m_woken_reg == '0))
        else $error("woken pid nonzero without handover");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVAL) |-> (eff.cnt <= CW'(QUEUE_DEPTH)))
        else $error("wait count above queue depth");

    a_waiters_locked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVAL && !eff.locked) |-> (eff.cnt == '0))
        else $error("waiters on a free mutex");

    a_wake_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        do_wake |=> (m_tvalid_reg && m_status_reg == mwq_pkg::ST_HANDED))
        else $error("handover result not presented");

endmodule

[hdl/mutex_unit_with_wait_queues.sv]
// Mutex bank with per-mutex FIFO wait queues: top level.
// Path: request beat into the front op queue, control entry read, then evaluation
// into the result register; a handover adds a wake state for the wait store read.
// The back end takes a new request only when done with the last one, as set by the
// read-then-write of the mutex control memory. Reset: all mutexes free at once via
// per-entry valid bits; no clearing pass. Depends on mwq_pkg, mwq_front and mwq_back.
module mutex_unit_with_wait_queues #(
    parameter int NUM_MUTEXES = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int PID_BITS    = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] mutex_id, [11:4] pid, [15:12] zero
    input  logic [15:0] s_tdata,
    // [0] kind
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] woken_pid
    output logic [7:0]  m_tdata,
    // [2:0] status
    output logic [2:0]  m_tuser
);

    logic         op_valid, op_ready;
    mwq_pkg::op_t op;

    mwq_front #(
        .NUM_MUTEXES (NUM_MUTEXES),
        .PID_BITS    (PID_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op)
    );

    mwq_back #(
        .NUM_MUTEXES (NUM_MUTEXES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PID_BITS    (PID_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .op       (op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
